// File: rtl/urx_pkg.sv
// urx_pkg: shared constants and types of the receive byte fifo
// no dependencies; imported by urx_ctrl and the top level, not by urx_ram
`timescale 1ns / 1ps

package urx_pkg;

  // ring size, one slot always stays free
  localparam int unsigned URX_DEPTH = 64;

  localparam int unsigned BYTE_W = 8;

  // command codes
  localparam logic [1:0] CMD_PUSH    = 2'd0;
  localparam logic [1:0] CMD_POP     = 2'd1;
  localparam logic [1:0] CMD_CONSUME = 2'd2;
  localparam logic [1:0] CMD_LOSS    = 2'd3;

  // line end characters
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;

  // result of one item, carried from the control unit to the result register
  typedef struct packed {
    logic ok;
    logic pop_ok;
    logic overflow;
    logic discard;
  } urx_result_t;

endpackage

// File: rtl/urx_ram.sv
// urx_ram: generic single write port ram with registered read
// depends on nothing
`timescale 1ns / 1ps

module urx_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/urx_ctrl.sv
// urx_ctrl: ring pointers, overflow flag and line resync discard state
// depends on urx_pkg; drives the write and read ports of the byte ram
`timescale 1ns / 1ps

module urx_ctrl #(
  parameter int unsigned Depth = urx_pkg::URX_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [1:0]                    command_i,
  input  logic [urx_pkg::BYTE_W-1:0]    data_in_i,
  output logic                          ram_we_o,
  output logic [$clog2(Depth)-1:0]      ram_waddr_o,
  output logic [urx_pkg::BYTE_W-1:0]    ram_wdata_o,
  output logic                          ram_re_o,
  output logic [$clog2(Depth)-1:0]      ram_raddr_o,
  output urx_pkg::urx_result_t          result_o
);

  import urx_pkg::*;

  localparam int unsigned IdxW = $clog2(Depth);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  logic [IdxW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic            ovf_q, ovf_d, disc_q, disc_d, cr_q, cr_d;
  logic [IdxW-1:0] wr_next, rd_next;
  logic            store, proceed, pop_ok, consume_ok;

  assign wr_next = (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
  assign rd_next = (rd_q == LastIdx) ? '0 : rd_q + 1'b1;

  always_comb begin
    wr_d       = wr_q;
    rd_d       = rd_q;
    ovf_d      = ovf_q;
    disc_d     = disc_q;
    cr_d       = cr_q;
    store      = 1'b0;
    proceed    = 1'b0;
    pop_ok     = 1'b0;
    consume_ok = 1'b0;
    case (command_i)
      CMD_PUSH: begin
        if (disc_q) begin
          if (cr_q) begin
            // cr then anything ends the discard, lf is swallowed
            cr_d    = 1'b0;
            disc_d  = 1'b0;
            proceed = (data_in_i != CHAR_LF);
          end else if (data_in_i == CHAR_CR) begin
            cr_d = 1'b1;
          end else if (data_in_i == CHAR_LF) begin
            disc_d = 1'b0;
          end
        end else begin
          proceed = 1'b1;
        end
        if (proceed) begin
          if (wr_next == rd_q) begin
            // full: drop everything and resync on next line end
            rd_d   = wr_q;
            ovf_d  = 1'b1;
            disc_d = 1'b1;
            cr_d   = 1'b0;
          end else begin
            store = 1'b1;
            wr_d  = wr_next;
          end
        end
      end
      CMD_POP: begin
        if (!ovf_q && !disc_q && (rd_q != wr_q)) begin
          pop_ok = 1'b1;
          rd_d   = rd_next;
        end
      end
      CMD_CONSUME: begin
        if (ovf_q) begin
          consume_ok = 1'b1;
          ovf_d      = 1'b0;
        end
      end
      CMD_LOSS: begin
        rd_d   = wr_q;
        ovf_d  = 1'b0;
        disc_d = 1'b1;
        cr_d   = 1'b0;
      end
      default: begin
        wr_d = wr_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      ovf_q  <= 1'b0;
      disc_q <= 1'b0;
      cr_q   <= 1'b0;
    end else if (accept_i) begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      ovf_q  <= ovf_d;
      disc_q <= disc_d;
      cr_q   <= cr_d;
    end
  end

  assign ram_we_o    = accept_i && store;
  assign ram_waddr_o = wr_q;
  assign ram_wdata_o = data_in_i;
  assign ram_re_o    = accept_i && pop_ok;
  assign ram_raddr_o = rd_q;

  assign result_o.ok       = pop_ok || consume_ok;
  assign result_o.pop_ok   = pop_ok;
  assign result_o.overflow = ovf_d;
  assign result_o.discard  = disc_d;

endmodule

// File: rtl/uart_rx_fifo_line_resync.sv
// uart_rx_fifo_line_resync: top level of the receive byte fifo
// depends on urx_pkg, urx_ctrl and urx_ram
`timescale 1ns / 1ps

// Receive byte fifo with overflow recovery and line resync.
// Input channel (in_valid_i / in_ready_o) carries one command item:
//   push data_in_i, pop, consume overflow flag, or mark loss.
// Output channel (out_valid_o / out_ready_i) returns exactly one result item
//   per command: ok, popped byte (zero unless a pop succeeded), and the
//   overflow and discard flags as they stand after the command.
// A full ring holds DEPTH-1 bytes; pushing into a full ring drops all held
//   bytes, raises overflow and discards input up to the next line end
//   (lf, cr, or cr lf).
// The result is registered and appears in the cycle after its item is accepted; the byte
//   comes straight from the registered read port of the byte ram.
// Throughput: one item per cycle while the result side is not stalled; pointer and flag
//   updates are plain increments and compares, and the ram takes one write or one read per item.
// Stall: the result register holds while out_ready_i is low, and the ram read
//   data holds with it since a read is only issued on accept; in_ready_o is
//   high whenever the result register is empty or being drained.
// Reset: pointers, flags and the result valid clear; the ring starts empty and
//   the ram contents are never read before being written.

module uart_rx_fifo_line_resync #(
  parameter int unsigned DEPTH = urx_pkg::URX_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 command_i,
  input  logic [urx_pkg::BYTE_W-1:0] data_in_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       ok_o,
  output logic [urx_pkg::BYTE_W-1:0] data_out_o,
  output logic                       overflow_pending_o,
  output logic                       discarding_o
);

  import urx_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);

  logic              accept;
  logic              ram_we, ram_re;
  logic [IdxW-1:0]   ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;
  urx_result_t       result;

  // result register
  logic              res_valid_q;
  urx_result_t       res_q;

  // new item may enter when the result slot is free or drains this cycle
  assign in_ready_o = !res_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  urx_ctrl #(
    .Depth(DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .command_i  (command_i),
    .data_in_i  (data_in_i),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .result_o   (result)
  );

  // byte storage of the ring
  urx_ram #(
    .Width(BYTE_W),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      res_valid_q <= accept;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= result;
    end
  end

  assign out_valid_o        = res_valid_q;
  assign ok_o               = res_q.ok;
  assign data_out_o         = res_q.pop_ok ? ram_rdata : '0;
  assign overflow_pending_o = res_q.overflow;
  assign discarding_o       = res_q.discard;

endmodule

// File: bench/tb.sv
// tb: self-checking bench for the receive byte fifo with line resync
// depends on urx_pkg and uart_rx_fifo_line_resync; holds its own predictor
`timescale 1ns / 1ps

module tb;
  import urx_pkg::*;

  // stimulus size and run limits
  localparam int unsigned ITEM_TARGET  = 1250;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned LONG_HOLD    = 160;
  localparam int unsigned DRAIN_CYCLES = 8;

  // one result item as the bench sees it
  typedef struct packed {
    logic              ok;
    logic [BYTE_W-1:0] data;
    logic              ovf;
    logic              disc;
  } rx_result_t;

  // one row of the directed table; typed rows carry their own expected result
  typedef struct packed {
    logic [1:0]        cmd;
    logic [BYTE_W-1:0] din;
    logic              typed;
    rx_result_t        x_res;
  } dir_row_t;

  // directed walk: after-reset pops, data extremes, every command, and the
  // discard exits (lf, cr lf, cr plus other byte, cr plus cr)
  localparam dir_row_t DIRECTED_ROWS [26] = '{
    '{CMD_POP,     8'h00,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}}, // pop on empty ring
    '{CMD_CONSUME, 8'h00,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}}, // consume with flag clear
    '{CMD_PUSH,    8'h00,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}},
    '{CMD_PUSH,    8'hFF,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}},
    '{CMD_POP,     8'h00,   1'b1, '{1'b1, 8'h00, 1'b0, 1'b0}},
    '{CMD_POP,     8'h00,   1'b1, '{1'b1, 8'hFF, 1'b0, 1'b0}},
    '{CMD_POP,     8'hFF,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}}, // empty again, data ignored
    '{CMD_LOSS,    8'hA5,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b1}},
    '{CMD_PUSH,    8'h41,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b1}}, // swallowed by discard
    '{CMD_POP,     8'h00,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b1}}, // pop refused while discarding
    '{CMD_PUSH,    CHAR_LF, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}}, // lf ends discard
    '{CMD_LOSS,    8'h00,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b1}},
    '{CMD_PUSH,    CHAR_CR, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1}},
    '{CMD_PUSH,    CHAR_LF, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}}, // cr lf ends discard
    '{CMD_POP,     8'h00,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}}, // lf was dropped
    '{CMD_LOSS,    8'h00,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b1}},
    '{CMD_PUSH,    CHAR_CR, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1}},
    '{CMD_PUSH,    8'h5A,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}}, // cr then other byte: kept
    '{CMD_POP,     8'h00,   1'b0, '0},
    '{CMD_LOSS,    8'h00,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b1}},
    '{CMD_PUSH,    CHAR_CR, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1}},
    '{CMD_PUSH,    CHAR_CR, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}}, // second cr is kept as data
    '{CMD_PUSH,    8'h80,   1'b0, '0},
    '{CMD_POP,     8'h00,   1'b0, '0},
    '{CMD_POP,     8'h00,   1'b0, '0},
    '{CMD_CONSUME, 8'h00,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        command_i;
  logic [BYTE_W-1:0] data_in_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              ok_o;
  logic [BYTE_W-1:0] data_out_o;
  logic              overflow_pending_o;
  logic              discarding_o;

  // predictor copy of the ring and its flags
  logic [BYTE_W-1:0] ring_bytes [URX_DEPTH];
  int unsigned       wr_ptr;
  int unsigned       rd_ptr;
  bit                ovf_flag;
  bit                discard_on;
  bit                cr_seen;

  // results still owed by the block, oldest first
  rx_result_t  owed_results [$];
  rx_result_t  want;
  int unsigned sent_items;
  int unsigned mismatches;
  int unsigned cycle_count = 0;

  // idling knobs, flipped per random burst; long hold asked by stimulus side
  bit send_idle;
  bit recv_idle;
  bit long_hold_req;

  uart_rx_fifo_line_resync u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .data_in_i          (data_in_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .ok_o               (ok_o),
    .data_out_o         (data_out_o),
    .overflow_pending_o (overflow_pending_o),
    .discarding_o       (discarding_o)
  );

  // 12 ns clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               owed_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one line per mismatch, and a count
  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("mismatch cycle %0d: %s got %0h expected %0h", cycle_count, what, got, exp_val);
    mismatches++;
  endtask

  // what the fifo answers to one command; updates the predictor state
  function automatic rx_result_t predict_command(input logic [1:0] cmd,
                                                 input logic [BYTE_W-1:0] din);
    rx_result_t  r;
    int unsigned nxt;
    bit          store_it;
    r = '0;
    case (cmd)
      CMD_PUSH: begin
        store_it = 1'b1;
        if (discard_on) begin
          if (cr_seen) begin
            // byte after a cr closes the discard; only lf is eaten
            cr_seen    = 1'b0;
            discard_on = 1'b0;
            if (din == CHAR_LF) store_it = 1'b0;
          end else begin
            if (din == CHAR_CR) cr_seen = 1'b1;
            else if (din == CHAR_LF) discard_on = 1'b0;
            store_it = 1'b0;
          end
        end
        if (store_it) begin
          nxt = (wr_ptr + 1) % URX_DEPTH;
          if (nxt == rd_ptr) begin
            // full ring: drop everything and resync on the next line end
            rd_ptr     = wr_ptr;
            ovf_flag   = 1'b1;
            discard_on = 1'b1;
            cr_seen    = 1'b0;
          end else begin
            ring_bytes[wr_ptr] = din;
            wr_ptr             = nxt;
          end
        end
      end
      CMD_POP: begin
        if (!ovf_flag && !discard_on && rd_ptr != wr_ptr) begin
          r.ok   = 1'b1;
          r.data = ring_bytes[rd_ptr];
          rd_ptr = (rd_ptr + 1) % URX_DEPTH;
        end
      end
      CMD_CONSUME: begin
        if (ovf_flag) begin
          ovf_flag = 1'b0;
          r.ok     = 1'b1;
        end
      end
      default: begin
        rd_ptr     = wr_ptr;
        ovf_flag   = 1'b0;
        discard_on = 1'b1;
        cr_seen    = 1'b0;
      end
    endcase
    r.ovf  = ovf_flag;
    r.disc = discard_on;
    return r;
  endfunction

  // offer one item after a random gap; called and returns at a falling edge
  task automatic send_item(input logic [1:0] cmd, input logic [BYTE_W-1:0] din,
                           input bit typed, input rx_result_t typed_res);
    int unsigned gap;
    rx_result_t  predicted;
    gap = send_idle ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    data_in_i  <= din;
    do @(posedge clk_i); while (!in_ready_o);
    // accepted at this edge; the predictor always runs to keep its state
    predicted = predict_command(cmd, din);
    owed_results.push_back(typed ? typed_res : predicted);
    sent_items++;
    @(negedge clk_i);
  endtask

  // random bursts: fills past full, drains, line-end recoveries, flag traffic, noise
  task automatic run_random_traffic(input int unsigned stop_at);
    int unsigned       burst;
    int unsigned       kind;
    int unsigned       n;
    int unsigned       ending;
    bit                hold_done;
    logic [1:0]        cmd;
    logic [BYTE_W-1:0] b;
    burst     = 0;
    hold_done = 1'b0;
    while (sent_items < stop_at) begin
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      // halfway through, the result side stops for a long while
      if (!hold_done && sent_items >= stop_at / 2) begin
        long_hold_req = 1'b1;
        hold_done     = 1'b1;
      end
      // first burst always overflows the ring, second consumes the flag
      if (burst == 0) kind = 0;
      else if (burst == 1) kind = 62;
      else kind = $urandom_range(0, 99);
      burst++;
      if (kind < 22) begin
        n = (burst == 1) ? URX_DEPTH : $urandom_range(20, 70);
        repeat (n) send_item(CMD_PUSH, 8'($urandom_range(0, 255)), 1'b0, '0);
      end else if (kind < 42) begin
        n = $urandom_range(1, 70);
        repeat (n) send_item(CMD_POP, 8'($urandom_range(0, 255)), 1'b0, '0);
      end else if (kind < 60) begin
        // line with junk, one of the line-end forms, then the next line
        n = $urandom_range(0, 6);
        repeat (n) send_item(CMD_PUSH, 8'($urandom_range(0, 255)), 1'b0, '0);
        ending = $urandom_range(0, 3);
        if (ending == 0) begin
          send_item(CMD_PUSH, CHAR_LF, 1'b0, '0);
        end else begin
          send_item(CMD_PUSH, CHAR_CR, 1'b0, '0);
          if (ending == 2) begin
            send_item(CMD_PUSH, CHAR_LF, 1'b0, '0);
          end else if (ending == 3) begin
            b = 8'($urandom_range(0, 255));
            if (b == CHAR_LF) b = CHAR_CR;
            send_item(CMD_PUSH, b, 1'b0, '0);
          end
        end
        n = $urandom_range(0, 8);
        repeat (n) send_item(CMD_PUSH, 8'($urandom_range(0, 255)), 1'b0, '0);
      end else if (kind < 70) begin
        n = $urandom_range(1, 2);
        repeat (n) send_item(CMD_CONSUME, 8'($urandom_range(0, 255)), 1'b0, '0);
      end else if (kind < 76) begin
        send_item(CMD_LOSS, 8'($urandom_range(0, 255)), 1'b0, '0);
      end else begin
        // noise: any command, data leaning toward cr and lf
        n = $urandom_range(1, 12);
        repeat (n) begin
          cmd = 2'($urandom_range(int'(CMD_PUSH), int'(CMD_LOSS)));
          if ($urandom_range(0, 3) == 0) b = $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
          else b = 8'($urandom_range(0, 255));
          send_item(cmd, b, 1'b0, '0);
        end
      end
    end
  endtask

  // result side: random stall per item, plus the one long hold
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (long_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        long_hold_req = 1'b0;
      end
      stall = recv_idle ? $urandom_range(0, 9) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // compare every accepted result against the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (owed_results.size() == 0) begin
        report_mismatch("result with no item outstanding", ok_o, 0);
      end else begin
        want = owed_results.pop_front();
        if (ok_o !== want.ok) report_mismatch("ok", ok_o, want.ok);
        if (data_out_o !== want.data) report_mismatch("data_out", data_out_o, want.data);
        if (overflow_pending_o !== want.ovf)
          report_mismatch("overflow_pending", overflow_pending_o, want.ovf);
        if (discarding_o !== want.disc)
          report_mismatch("discarding", discarding_o, want.disc);
      end
    end
  end

  // reset, directed table, random traffic, drain, verdict
  initial begin
    int unsigned row;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    command_i     = CMD_PUSH;
    data_in_i     = '0;
    send_idle     = 1'b1;
    recv_idle     = 1'b1;
    long_hold_req = 1'b0;
    sent_items    = 0;
    mismatches    = 0;
    wr_ptr        = 0;
    rd_ptr        = 0;
    ovf_flag      = 1'b0;
    discard_on    = 1'b0;
    cr_seen       = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (row = 0; row < $size(DIRECTED_ROWS); row++) begin
      send_item(DIRECTED_ROWS[row].cmd, DIRECTED_ROWS[row].din,
                DIRECTED_ROWS[row].typed, DIRECTED_ROWS[row].x_res);
    end

    run_random_traffic($size(DIRECTED_ROWS) + ITEM_TARGET);
    in_valid_i <= 1'b0;

    // wait for every owed result, then keep watching for strays
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/urx_pkg.sv
rtl/urx_ram.sv
rtl/urx_ctrl.sv
rtl/uart_rx_fifo_line_resync.sv
bench/tb.sv
